>>> rtl/sti_pkg.sv
// Package for the sorted table insert and binary search core.
// Holds the beat payload types, operation codes, FSM states and the
// command and status groups shared by the controller and the datapath.
package sti_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W = 4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic operation;
      logic signed [VALUE_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic found;
      logic [POS_W-1:0] match_position;
      logic status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_ins;
      logic rd_srch;
      logic wr_shift;
      logic wr_value;
      logic set_full;
      logic set_found;
      logic go_right;
      logic go_left;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic j_zero;
      logic range_empty;
      logic less;
      logic equal;
      logic greater;
   } stat_type;

endpackage

>>> rtl/sorted_table_insert_binary_search_core.sv
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_type: operation, item_value
// rsp      out        rsp_valid/stall    rsp_type: found, match_position, status
//
// One item at a time; a new request is taken only when idle. An insert reads and shifts
// the larger entries up one place, then writes the value; a search probes until a hit or
// an empty range; an insert into a full table is refused. Each step waits on the
// table RAM read. Reset (synchronous) empties the table by clearing the entry count.
// The result sits in an output register, so a stalled rsp beat does not block
// the next request; rsp stall only holds the block once a second result is ready.
module sorted_table_insert_binary_search_core
   import sti_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type  cmd;
   stat_type stat;

   sti_controller u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_operation(req_payload.operation),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .stat         (stat),
      .cmd          (cmd)
   );

   sti_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_payload(rsp_payload)
   );

endmodule

>>> rtl/sti_ram.sv
// Generic single write port, single read port RAM with registered read.
// Stands alone; no package dependency.
module sti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sti_datapath.sv
// Datapath of the sorted table core: table RAM, entry count, insert cursor,
// search bounds and result registers. Uses sti_pkg and sti_ram.
module sti_datapath
   import sti_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_payload,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_payload
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hend_ff, hend_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   rsp_type result_ff, result_in;
   rsp_type out_ff, out_in;

   logic [CNT_W:0] mid_sum;
   logic [CNT_W-1:0] mid_wide;
   logic [CNT_W-1:0] j_m1;
   logic [IDX_W+POS_W-1:0] pos_ext;
   logic signed [VALUE_W-1:0] entry;

   logic ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [VALUE_W-1:0] ram_wr_data, ram_rd_data;

   // The search range is [lo, hend); the probe is floor((lo + hend - 1) / 2).
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hend_ff} - {{CNT_W{1'b0}}, 1'b1};
   assign mid_wide = mid_sum[CNT_W:1];
   assign j_m1 = j_ff - {{(CNT_W-1){1'b0}}, 1'b1};
   assign pos_ext = {{POS_W{1'b0}}, mid_ff};
   assign entry = $signed(ram_rd_data);

   assign ram_rd_en = cmd.rd_ins | cmd.rd_srch;
   assign ram_rd_addr = cmd.rd_srch ? mid_wide[IDX_W-1:0] : j_m1[IDX_W-1:0];
   assign ram_wr_en = cmd.wr_shift | cmd.wr_value;
   assign ram_wr_addr = j_ff[IDX_W-1:0];
   assign ram_wr_data = cmd.wr_shift ? ram_rd_data : value_ff;

   sti_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      stat.full = (count_ff == CNT_W'(TABLE_DEPTH));
      stat.j_zero = (j_ff == '0);
      stat.range_empty = (hend_ff <= lo_ff);
      stat.less = (value_ff < entry);
      stat.equal = (value_ff == entry);
      stat.greater = (value_ff > entry);
   end

   always_comb begin
      count_in = count_ff;
      j_in = j_ff;
      lo_in = lo_ff;
      hend_in = hend_ff;
      mid_in = mid_ff;
      value_in = value_ff;
      result_in = result_ff;
      out_in = out_ff;
      if (cmd.load) begin
         value_in = req_payload.item_value;
         j_in = count_ff;
         lo_in = '0;
         hend_in = count_ff;
         result_in.found = 1'b0;
         result_in.match_position = '0;
         result_in.status = STATUS_OK;
      end
      if (cmd.rd_srch) begin
         mid_in = mid_wide[IDX_W-1:0];
      end
      if (cmd.wr_shift) begin
         j_in = j_m1;
      end
      if (cmd.wr_value) begin
         count_in = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
      end
      if (cmd.set_full) begin
         result_in.status = STATUS_FULL;
      end
      if (cmd.set_found) begin
         result_in.found = 1'b1;
         result_in.match_position = pos_ext[POS_W-1:0];
      end
      if (cmd.go_right) begin
         lo_in = CNT_W'(mid_ff) + {{(CNT_W-1){1'b0}}, 1'b1};
      end
      if (cmd.go_left) begin
         hend_in = CNT_W'(mid_ff);
      end
      if (cmd.out_load) begin
         out_in = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      j_ff <= j_in;
      lo_ff <= lo_in;
      hend_ff <= hend_in;
      mid_ff <= mid_in;
      value_ff <= value_in;
      result_ff <= result_in;
      out_ff <= out_in;
   end

   assign rsp_payload = out_ff;

endmodule

>>> rtl/sti_controller.sv
// Controller of the sorted table core: sequences insert shifts and search
// probes and owns the response valid. Uses sti_pkg.
module sti_controller
   import sti_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_operation,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_operation == OP_INSERT) ? ST_INS_RD : ST_SRCH_RD;
            end
         end
         ST_INS_RD: begin
            if (stat.full || stat.j_zero) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            state_in = stat.less ? ST_INS_RD : ST_RESULT;
         end
         ST_SRCH_RD: begin
            state_in = stat.range_empty ? ST_RESULT : ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            state_in = stat.equal ? ST_RESULT : ST_SRCH_RD;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         ST_INS_RD: begin
            if (stat.full) begin
               cmd.set_full = 1'b1;
            end else if (stat.j_zero) begin
               cmd.wr_value = 1'b1;
            end else begin
               cmd.rd_ins = 1'b1;
            end
         end
         ST_INS_CMP: begin
            // Larger entries move up one place; otherwise the new value lands here.
            if (stat.less) begin
               cmd.wr_shift = 1'b1;
            end else begin
               cmd.wr_value = 1'b1;
            end
         end
         ST_SRCH_RD: begin
            cmd.rd_srch = ~stat.range_empty;
         end
         ST_SRCH_CMP: begin
            if (stat.equal) begin
               cmd.set_found = 1'b1;
            end else if (stat.greater) begin
               cmd.go_right = 1'b1;
            end else begin
               cmd.go_left = 1'b1;
            end
         end
         ST_RESULT: begin
            cmd.out_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Testbench for sorted_table_insert_binary_search_core: directed beats, then random ones.
// Results are checked against a shadow copy of the sorted table.
// Depends on sti_pkg and the core RTL only.

module testbench;
   import sti_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 1125;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam rsp_type RSP_CLEAN = '{found: 1'b0, match_position: '0, status: STATUS_OK};
   localparam rsp_type RSP_REFUSED = '{found: 1'b0, match_position: '0, status: STATUS_FULL};

   typedef struct packed {
      req_type beat;
      logic typed;
      rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_payload;

   // Shadow of the table contents and fill level.
   logic signed [VALUE_W-1:0] shadow_table [TABLE_DEPTH];
   int shadow_fill = 0;

   rsp_type pending_results[$];
   rsp_type oldest;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int send_pace = 0;
   int cycle_count = 0;
   int inserts_done = 0;
   int inserts_refused = 0;
   int searches_done = 0;
   int search_hits = 0;

   sorted_table_insert_binary_search_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Applies one beat to the shadow table and returns the result it must produce.
   function automatic rsp_type apply_to_shadow(req_type beat);
      rsp_type res;
      logic signed [VALUE_W-1:0] v;
      int lo, hi, mid, j;
      res = RSP_CLEAN;
      v = beat.item_value;
      if (beat.operation == OP_INSERT) begin
         if (shadow_fill >= TABLE_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            j = shadow_fill;
            while (j > 0 && v < shadow_table[j-1]) begin
               shadow_table[j] = shadow_table[j-1];
               j--;
            end
            shadow_table[j] = v;
            shadow_fill++;
         end
      end else begin
         lo = 0;
         hi = shadow_fill - 1;
         while (hi >= lo && !res.found) begin
            mid = (lo + hi) / 2;
            if (shadow_table[mid] == v) begin
               res.found = 1'b1;
               res.match_position = mid[POS_W-1:0];
            end else if (v > shadow_table[mid]) begin
               lo = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end
      end
      return res;
   endfunction

   function automatic stim_row_type row(logic op, logic signed [VALUE_W-1:0] val,
                                        logic typed, rsp_type want);
      stim_row_type r;
      r.beat.operation = op;
      r.beat.item_value = val;
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   // Idle length for one gap; pace 0 never idles, 1 idles lightly, 2 heavily.
   function automatic int pick_idle(int pace);
      int r;
      r = $urandom_range(0, 99);
      case (pace)
         0: return 0;
         1: begin
            if (r < 80) return 0;
            if (r < 97) return $urandom_range(1, 3);
            return $urandom_range(8, 40);
         end
         default: begin
            if (r < 35) return 0;
            if (r < 85) return $urandom_range(1, 4);
            return $urandom_range(10, 40);
         end
      endcase
   endfunction

   // Mostly values already in the table or next to one, so searches hit and
   // duplicates get probed; the rest is fully random or at the extremes.
   function automatic req_type random_beat();
      req_type b;
      int pick;
      b.operation = ($urandom_range(0, 99) < 25) ? OP_INSERT : OP_SEARCH;
      pick = $urandom_range(0, 9);
      if (shadow_fill > 0 && pick < 5) begin
         b.item_value = shadow_table[$urandom_range(0, shadow_fill - 1)];
      end else if (shadow_fill > 0 && pick < 7) begin
         b.item_value = shadow_table[$urandom_range(0, shadow_fill - 1)]
                        + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
      end else if (pick == 7) begin
         b.item_value = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      end else begin
         b.item_value = $urandom();
      end
      return b;
   endfunction

   task automatic send_beat(input req_type beat, input logic typed, input rsp_type want);
      rsp_type predicted;
      req_type junk;
      int gap;
      gap = pick_idle(send_pace);
      if (gap > 0) begin
         junk.operation = $urandom_range(0, 1);
         junk.item_value = $urandom();
         req_valid <= 1'b0;
         req_payload <= junk;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      predicted = apply_to_shadow(beat);
      if (beat.operation == OP_INSERT) begin
         if (predicted.status == STATUS_FULL) inserts_refused++;
         else inserts_done++;
      end else begin
         searches_done++;
         if (predicted.found) search_hits++;
      end
      pending_results.insert(pending_results.size(), typed ? want : predicted);
      @(negedge clock);
   endtask

   // Result side: stall bursts whose density steps through three modes, the first without stalls.
   initial begin : rsp_backpressure
      int hold_left;
      int mode;
      logic stall_now;
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (hold_left > 0) begin
            hold_left--;
         end else begin
            mode = (cycle_count / 300) % 3;
            stall_now = (mode != 0) && ($urandom_range(0, 99) < ((mode == 1) ? 25 : 55));
            rsp_stall <= stall_now;
            hold_left = stall_now ? pick_idle(mode) : $urandom_range(0, 3);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected: found %0d position %0d status %0d",
                     $time, rsp_payload.found, rsp_payload.match_position, rsp_payload.status);
            mismatch_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_payload.found !== oldest.found) begin
               $display("%0t: found mismatch: expected %0d, actual %0d",
                        $time, oldest.found, rsp_payload.found);
               mismatch_count++;
            end
            if (rsp_payload.match_position !== oldest.match_position) begin
               $display("%0t: match_position mismatch: expected %0d, actual %0d",
                        $time, oldest.match_position, rsp_payload.match_position);
               mismatch_count++;
            end
            if (rsp_payload.status !== oldest.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, oldest.status, rsp_payload.status);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      stim_row_type rows[$];
      int n;
      req_valid = 1'b0;
      req_payload = '0;
      rows = '{
         // Searches on the empty table make no probe.
         row(OP_SEARCH, 32'sd0, 1'b1, RSP_CLEAN),
         row(OP_SEARCH, VALUE_MIN, 1'b1, RSP_CLEAN),
         row(OP_INSERT, VALUE_MAX, 1'b1, RSP_CLEAN),
         row(OP_INSERT, VALUE_MIN, 1'b1, RSP_CLEAN),
         row(OP_SEARCH, VALUE_MAX, 1'b0, RSP_CLEAN),
         row(OP_SEARCH, VALUE_MIN, 1'b0, RSP_CLEAN),
         // A run of equal values; the search need not land on the lowest one.
         row(OP_INSERT, 32'sd5, 1'b1, RSP_CLEAN),
         row(OP_INSERT, 32'sd5, 1'b1, RSP_CLEAN),
         row(OP_INSERT, 32'sd5, 1'b1, RSP_CLEAN),
         row(OP_INSERT, 32'sd5, 1'b1, RSP_CLEAN),
         row(OP_INSERT, -32'sd5, 1'b1, RSP_CLEAN),
         row(OP_INSERT, 32'sd0, 1'b1, RSP_CLEAN),
         row(OP_INSERT, -32'sd1, 1'b1, RSP_CLEAN),
         row(OP_SEARCH, 32'sd5, 1'b0, RSP_CLEAN),
         row(OP_SEARCH, 32'sd6, 1'b0, RSP_CLEAN),
         row(OP_INSERT, VALUE_MAX, 1'b1, RSP_CLEAN),
         row(OP_INSERT, VALUE_MIN, 1'b1, RSP_CLEAN),
         row(OP_INSERT, 32'sd3, 1'b1, RSP_CLEAN),
         row(OP_INSERT, 32'sd2, 1'b1, RSP_CLEAN),
         row(OP_INSERT, 32'sd4, 1'b1, RSP_CLEAN),
         row(OP_INSERT, 32'sd6, 1'b1, RSP_CLEAN),
         row(OP_INSERT, 32'sd7, 1'b1, RSP_CLEAN),
         // The table is full now, so further inserts are refused.
         row(OP_INSERT, 32'sd0, 1'b1, RSP_REFUSED),
         row(OP_SEARCH, 32'sd5, 1'b0, RSP_CLEAN),
         row(OP_SEARCH, VALUE_MIN, 1'b0, RSP_CLEAN),
         row(OP_SEARCH, VALUE_MAX, 1'b0, RSP_CLEAN)
      };
      wait (!reset);
      @(negedge clock);
      foreach (rows[i]) begin
         send_pace = $urandom_range(0, 2);
         send_beat(rows[i].beat, rows[i].typed, rows[i].want);
      end
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) send_pace = (n / 150) % 3;
         send_beat(random_beat(), 1'b0, RSP_CLEAN);
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d accepted and %0d refused inserts, %0d searches with %0d hits,",
               inserts_done, inserts_refused, searches_done, search_hits);
      $display("with random gaps on the request side and random stalls on the result side.");
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
